FILE: rtl/core/uart_bit_receiver_defines.svh
// ----------------------------------------------------------------------------
// UART bit receiver assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef UART_BIT_RECEIVER_DEFINES_SVH
`define UART_BIT_RECEIVER_DEFINES_SVH

// same-cycle implication
`define URX_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define URX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/uart_rx_pkg.sv
// ----------------------------------------------------------------------------
// UART bit receiver package
// Field widths, register indexes, parity modes and the result type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package uart_rx_pkg;

  localparam int unsigned DATA_W  = 9;
  localparam int unsigned FRAME_W = 12;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned CFG_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DATA_WIDTH  = 2'd0,
    CFG_PARITY_MODE = 2'd1,
    CFG_STOP_COUNT  = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PAR_NONE  = 3'd0,
    PAR_EVEN  = 3'd1,
    PAR_ODD   = 3'd2,
    PAR_MARK  = 3'd3,
    PAR_SPACE = 3'd4
  } parity_mode_e;

  typedef struct packed {
    logic              break_seen;
    logic              framing_error;
    logic              parity_error;
    logic [DATA_W-1:0] received_data;
  } rx_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/uart_bit_receiver.sv
// ----------------------------------------------------------------------------
// UART bit receiver
// Frames sampled line bits into data words with parity, framing and break
// flags.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one sampled line bit per transaction in
//   s_axis_tdata_i[0]. While idle, a 0 after a 1 starts a frame; the next
//   data, parity and stop bits are collected LSB first. The transaction that
//   carries the last stop bit produces one result transaction on the output
//   stream: data word plus parity error, framing error and break flags.
//   The result is registered in the output register, or in the skid register if stalled.
//   Throughput: one bit per cycle while s_axis_tready_o is high; every bit is
//   handled by a single level of logic between state and result registers.
//   The output register is backed by a one-entry skid register, so input
//   keeps flowing while a result waits. s_axis_tready_o drops only while the
//   skid register is full, i.e. two results are waiting.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at
//   once: index 0 data width, 1 parity mode, 2 stop count.
//   Reset returns to idle with 8 data bits, no parity, one stop bit, and
//   drops any pending result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "uart_bit_receiver_defines.svh"

module uart_bit_receiver #(
  parameter int unsigned MAX_DATA_BITS = 9
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [uart_rx_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [uart_rx_pkg::CFG_W-1:0]   cfg_data_i,
  input  wire logic                            s_axis_tvalid_i,
  output      logic                            s_axis_tready_o,
  // [0] line_bit, [7:1] zero
  input  wire logic [7:0]                      s_axis_tdata_i,
  output      logic                            m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // [8:0] received_data, [9] parity_error, [10] framing_error,
  // [11] break_seen, [15:12] zero
  output      logic [15:0]                     m_axis_tdata_o
);

  localparam logic [uart_rx_pkg::IDX_W-1:0] MaxDw = uart_rx_pkg::IDX_W'(MAX_DATA_BITS);

  logic [uart_rx_pkg::CFG_W-1:0] data_width_q;
  logic [2:0]                    parity_mode_q;
  logic [1:0]                    stop_count_q;

  logic                              prev_q, prev_d;
  logic                              rx_q, rx_d;
  logic [uart_rx_pkg::IDX_W-1:0]     idx_q, idx_d;
  logic [uart_rx_pkg::FRAME_W-1:0]   shift_q, shift_d;

  uart_rx_pkg::rx_result_t out_q, skid_q, res;
  logic                    out_vld_q, skid_vld_q;

  logic                              in_acc;
  logic                              bit_in;
  logic [uart_rx_pkg::IDX_W-1:0]     dw, len, idx_inc;
  logic                              par_on;
  logic [1:0]                        sc;
  logic [uart_rx_pkg::FRAME_W-1:0]   shift_new, frame;
  logic [uart_rx_pkg::DATA_W-1:0]    data;
  logic                              expected;
  logic                              r_vld;
  logic                              out_load;
  uart_rx_pkg::parity_mode_e         pm;

  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign bit_in          = s_axis_tdata_i[0];
  assign s_axis_tready_o = !skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_width_q  <= 4'd8;
      parity_mode_q <= uart_rx_pkg::PAR_NONE;
      stop_count_q  <= 2'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        uart_rx_pkg::CFG_DATA_WIDTH:  data_width_q  <= cfg_data_i;
        uart_rx_pkg::CFG_PARITY_MODE: parity_mode_q <= cfg_data_i[2:0];
        uart_rx_pkg::CFG_STOP_COUNT:  stop_count_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (data_width_q == '0) begin
      dw = 4'd1;
    end else if (data_width_q > MaxDw) begin
      dw = MaxDw;
    end else begin
      dw = data_width_q;
    end
    case (parity_mode_q)
      uart_rx_pkg::PAR_EVEN:  pm = uart_rx_pkg::PAR_EVEN;
      uart_rx_pkg::PAR_ODD:   pm = uart_rx_pkg::PAR_ODD;
      uart_rx_pkg::PAR_MARK:  pm = uart_rx_pkg::PAR_MARK;
      uart_rx_pkg::PAR_SPACE: pm = uart_rx_pkg::PAR_SPACE;
      default:                pm = uart_rx_pkg::PAR_NONE;
    endcase
    par_on = (pm != uart_rx_pkg::PAR_NONE);
    sc     = (stop_count_q == 2'd0) ? 2'd1 : ((stop_count_q == 2'd3) ? 2'd2 : stop_count_q);
    len    = dw + {3'd0, par_on} + {2'd0, sc};
  end

  always_comb begin
    idx_inc = idx_q + 4'd1;
    for (int i = 0; i < uart_rx_pkg::FRAME_W; i++) begin
      shift_new[i] = shift_q[i] | (bit_in & (idx_q == uart_rx_pkg::IDX_W'(i)));
      frame[i]     = shift_new[i] & (uart_rx_pkg::IDX_W'(i) < len);
    end
    for (int i = 0; i < uart_rx_pkg::DATA_W; i++) begin
      data[i] = frame[i] & (uart_rx_pkg::IDX_W'(i) < dw);
    end
    case (pm)
      uart_rx_pkg::PAR_EVEN: expected = ^data;
      uart_rx_pkg::PAR_ODD:  expected = ~^data;
      uart_rx_pkg::PAR_MARK: expected = 1'b1;
      default:               expected = 1'b0;
    endcase
    res.received_data = data;
    res.parity_error  = par_on & (frame[dw] != expected);
    res.framing_error = !frame[len - 4'd1];
    res.break_seen    = (frame == '0);
  end

  always_comb begin
    prev_d  = prev_q;
    rx_d    = rx_q;
    idx_d   = idx_q;
    shift_d = shift_q;
    r_vld   = 1'b0;
    if (in_acc) begin
      if (!rx_q) begin
        if (!bit_in && prev_q) begin
          rx_d    = 1'b1;
          idx_d   = '0;
          shift_d = '0;
        end else begin
          prev_d = bit_in;
        end
      end else begin
        prev_d  = bit_in;
        shift_d = shift_new;
        if (idx_inc < len) begin
          idx_d = idx_inc;
        end else begin
          rx_d  = 1'b0;
          idx_d = '0;
          r_vld = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b0;
      rx_q    <= 1'b0;
      idx_q   <= '0;
      shift_q <= '0;
    end else begin
      prev_q  <= prev_d;
      rx_q    <= rx_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
    end
  end

  assign out_load = !out_vld_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_load) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= r_vld;
      end
    end else if (r_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= skid_vld_q ? skid_q : res;
    end else if (r_vld) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'd0, out_q};

  `URX_ASSERT_IMPL(a_skid_behind_out, skid_vld_q, out_vld_q, "skid full while output empty")
  `URX_ASSERT_NEXT(a_idle_after_result, r_vld, !rx_q, "receiver not idle after a result")
  `URX_ASSERT_IMPL(a_idle_index_zero, !rx_q, idx_q == '0, "bit index not cleared while idle")
  `URX_ASSERT_IMPL(a_index_in_frame, rx_q, idx_q < uart_rx_pkg::IDX_W'(uart_rx_pkg::FRAME_W),
                   "bit index beyond frame")

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART bit receiver testbench
// Streams sampled line bits (framed words, parity and stop faults, breaks and
// line noise) through a range of register settings, and compares each
// result transaction with a frame predictor that tracks the line in step.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 125;
  localparam int unsigned MAX_REPORTS = 20;

  typedef enum int {FR_CLEAN, FR_BAD_PARITY, FR_FRAMING, FR_BREAK} frame_kind_e;

  class rx_frame_scoreboard;
    logic [3:0]              width_reg;
    logic [2:0]              parity_reg;
    logic [1:0]              stop_reg;
    logic                    prev_bit;
    logic                    in_frame;
    logic [3:0]              bit_cnt;
    logic [11:0]             shift_reg;
    uart_rx_pkg::rx_result_t pending[$];
    int unsigned             errors;

    function new();
      width_reg  = 4'd8;
      parity_reg = uart_rx_pkg::PAR_NONE;
      stop_reg   = 2'd1;
      prev_bit   = 1'b0;
      in_frame   = 1'b0;
      bit_cnt    = '0;
      shift_reg  = '0;
      errors     = 0;
    endfunction

    function void write_reg(uart_rx_pkg::cfg_reg_e idx, logic [uart_rx_pkg::CFG_W-1:0] val);
      case (idx)
        uart_rx_pkg::CFG_DATA_WIDTH:  width_reg  = val[3:0];
        uart_rx_pkg::CFG_PARITY_MODE: parity_reg = val[2:0];
        uart_rx_pkg::CFG_STOP_COUNT:  stop_reg   = val[1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      if (width_reg < 1) return 1;
      if (width_reg > 9) return 9;
      return width_reg;
    endfunction

    function logic [2:0] eff_parity();
      return (parity_reg > uart_rx_pkg::PAR_SPACE) ? uart_rx_pkg::PAR_NONE : parity_reg;
    endfunction

    function int unsigned eff_stop();
      if (stop_reg < 1) return 1;
      if (stop_reg > 2) return 2;
      return stop_reg;
    endfunction

    function logic parity_for(logic [8:0] data, logic [2:0] pm);
      case (pm)
        uart_rx_pkg::PAR_EVEN: return ^data;
        uart_rx_pkg::PAR_ODD:  return ~^data;
        uart_rx_pkg::PAR_MARK: return 1'b1;
        default:               return 1'b0;
      endcase
    endfunction

    function void note_line_bit(logic b);
      int unsigned             dw;
      int unsigned             len;
      logic [2:0]              pm;
      logic [12:0]             mask;
      logic [11:0]             frame;
      logic [8:0]              data;
      uart_rx_pkg::rx_result_t r;
      if (!in_frame) begin
        if (!b && prev_bit) begin
          in_frame  = 1'b1;
          bit_cnt   = '0;
          shift_reg = '0;
        end else begin
          prev_bit = b;
        end
        return;
      end
      dw  = eff_width();
      pm  = eff_parity();
      len = dw + ((pm != uart_rx_pkg::PAR_NONE) ? 1 : 0) + eff_stop();
      shift_reg = shift_reg | (12'(b) << bit_cnt);
      bit_cnt   = bit_cnt + 4'd1;
      prev_bit  = b;
      if (bit_cnt < len) return;
      in_frame = 1'b0;
      bit_cnt  = '0;
      mask  = (13'd1 << len) - 13'd1;
      frame = shift_reg & mask[11:0];
      data  = frame[8:0] & 9'((10'd1 << dw) - 10'd1);
      r.received_data = data;
      r.parity_error  = (pm != uart_rx_pkg::PAR_NONE) && (frame[dw] != parity_for(data, pm));
      r.framing_error = !frame[len-1];
      r.break_seen    = (frame == '0);
      pending.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    task check_result(logic [15:0] word);
      uart_rx_pkg::rx_result_t got;
      uart_rx_pkg::rx_result_t want;
      got = uart_rx_pkg::rx_result_t'(word[11:0]);
      if (pending.size() == 0) begin
        report($sformatf("unexpected result 0x%04h", word));
        return;
      end
      want = pending.pop_front();
      if (got.received_data != want.received_data)
        report($sformatf("data got 0x%03h want 0x%03h", got.received_data,
                         want.received_data));
      if (got.parity_error != want.parity_error)
        report($sformatf("parity_error got %b want %b", got.parity_error,
                         want.parity_error));
      if (got.framing_error != want.framing_error)
        report($sformatf("framing_error got %b want %b", got.framing_error,
                         want.framing_error));
      if (got.break_seen != want.break_seen)
        report($sformatf("break_seen got %b want %b", got.break_seen, want.break_seen));
      if (word[15:12] != 4'd0)
        report($sformatf("pad bits got 0x%01h", word[15:12]));
    endtask
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  uart_rx_pkg::cfg_reg_e         cfg_idx = uart_rx_pkg::CFG_DATA_WIDTH;
  logic [uart_rx_pkg::CFG_W-1:0] cfg_data = '0;
  logic                          s_tvalid = 1'b0;
  logic [7:0]                    s_tdata = '0;
  logic                          s_tready;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [15:0]                   m_tdata;

  rx_frame_scoreboard sb;

  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  bit          sender_idles = 1'b1;
  int unsigned stall_mode = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned quiet = 0;

  uart_bit_receiver dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int unsigned hold_cnt;
    int unsigned rcv_cyc;
    hold_cnt = 0;
    rcv_cyc  = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk_i);
      rcv_cyc++;
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        hold_cnt++;
        if (hold_cnt >= HOLD_CYCLES) hold_done = 1'b1;
      end else begin
        case (stall_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= (rcv_cyc % 9) > 2;
        endcase
      end
    end
  end

  task automatic send_bit(logic b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = sender_idles ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, b};
    do @(posedge clk_i); while (!s_tready);
    sb.note_line_bit(b);
    items_sent++;
  endtask

  task automatic send_frame(frame_kind_e kind);
    int unsigned dw;
    int unsigned sc;
    logic [2:0]  pm;
    logic [8:0]  data;
    logic        pbit;
    dw = sb.eff_width();
    pm = sb.eff_parity();
    sc = sb.eff_stop();
    repeat ($urandom_range(1, 3)) send_bit(1'b1);
    send_bit(1'b0);
    data = (kind == FR_BREAK) ? 9'd0 : 9'($urandom) & 9'((10'd1 << dw) - 10'd1);
    for (int k = 0; k < dw; k++) send_bit(data[k]);
    if (pm != uart_rx_pkg::PAR_NONE) begin
      pbit = sb.parity_for(data, pm);
      if (kind == FR_BAD_PARITY) pbit = ~pbit;
      if (kind == FR_BREAK) pbit = 1'b0;
      send_bit(pbit);
    end
    for (int k = 0; k < sc; k++) begin
      send_bit(!(kind == FR_BREAK || (kind == FR_FRAMING && k == sc - 1)));
    end
  endtask

  task automatic send_traffic(int unsigned n);
    int unsigned target;
    int unsigned pick;
    target = items_sent + n;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      send_frame(FR_CLEAN);
      else if (pick < 70) send_frame(FR_BAD_PARITY);
      else if (pick < 78) send_frame(FR_FRAMING);
      else if (pick < 84) send_frame(FR_BREAK);
      else if (pick < 94) repeat ($urandom_range(1, 15)) send_bit(1'($urandom_range(0, 1)));
      else                repeat (12) send_bit(1'b1);
    end
    repeat (12) send_bit(1'b1);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(uart_rx_pkg::cfg_reg_e idx, logic [uart_rx_pkg::CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic configure(logic [3:0] width, logic [2:0] parity, logic [1:0] stops);
    write_reg(uart_rx_pkg::CFG_DATA_WIDTH, width);
    write_reg(uart_rx_pkg::CFG_PARITY_MODE, uart_rx_pkg::CFG_W'(parity));
    write_reg(uart_rx_pkg::CFG_STOP_COUNT, uart_rx_pkg::CFG_W'(stops));
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [3:0] widths[10];
    logic [2:0] parities[10];
    logic [1:0] stops[10];
    sb = new();
    widths   = '{4'd1, 4'd9, 4'd0, 4'd15, 4'd5, 4'd7, 4'd8, 4'd9, 4'd0, 4'd0};
    parities = '{uart_rx_pkg::PAR_NONE, uart_rx_pkg::PAR_EVEN, uart_rx_pkg::PAR_ODD,
                 uart_rx_pkg::PAR_MARK, uart_rx_pkg::PAR_SPACE, 3'd6, uart_rx_pkg::PAR_ODD,
                 3'd7, uart_rx_pkg::PAR_NONE, uart_rx_pkg::PAR_NONE};
    stops    = '{2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1};
    parities[5] = 3'($urandom_range(5, 7));
    for (int p = 8; p < 10; p++) begin
      widths[p]   = 4'($urandom_range(0, 15));
      parities[p] = 3'($urandom_range(0, 7));
      stops[p]    = 2'($urandom_range(0, 3));
    end

    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // all-ones word, then a break that also fails the stop bit
    send_bit(1'b1);
    send_bit(1'b0);
    repeat (8) send_bit(1'b1);
    send_bit(1'b1);
    send_bit(1'b0);
    repeat (9) send_bit(1'b0);
    repeat (2) send_bit(1'b1);
    drain();

    for (int p = 0; p < 10; p++) begin
      configure(widths[p], parities[p], stops[p]);
      stall_mode   = p % 3;
      sender_idles = (p % 4) != 3;
      if (p == 1) hold_req = 1'b1;
      if (p == 4) begin
        send_traffic(PHASE_ITEMS / 2);
        drain();
        send_traffic(PHASE_ITEMS / 2);
      end else begin
        send_traffic(PHASE_ITEMS);
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
